[rtl/scale_link_watchdog_receiver_assert.svh]
// ----------------------------------------------------------------------------
// Scale link watchdog receiver assertion macros
// Shared clocked assertion forms, sampled at clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SCALE_LINK_WATCHDOG_RECEIVER_ASSERT_SVH
`define SCALE_LINK_WATCHDOG_RECEIVER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define SLW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slw assertion failed");

// Consequent holds in the cycle after the antecedent
`define SLW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slw assertion failed");

`endif

[rtl/slw_pkg.sv]
// ----------------------------------------------------------------------------
// Scale link watchdog receiver package
// Sizes, event and register codes, and the structs shared by the block.
// ----------------------------------------------------------------------------
package slw_pkg;

  // Weight buffer and command sizes
  localparam int WEIGHT_DEPTH = 16;
  localparam int CMD_LEN      = 2;
  localparam int IDX_W        = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WEIGHT_DEPTH + 1);
  localparam int POS_W        = (CMD_LEN > 1) ? $clog2(CMD_LEN) : 1;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int FUNC_W    = 3;
  localparam int RIDX_W    = 4;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] WD_MAX = '1;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] XON_RST   = 8'd17;
  localparam logic [BYTE_W-1:0] XOFF_RST  = 8'd19;
  localparam logic [BYTE_W-1:0] FAULT_RST = 8'd100;
  localparam logic [BYTE_W-1:0] RETRY_RST = 8'd200;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK    = 3'd0,
    FN_RX      = 3'd1,
    FN_TX_SLOT = 3'd2,
    FN_START   = 3'd3,
    FN_RUN     = 3'd4,
    FN_READ    = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    RESEND_NONE   = 2'd0,
    RESEND_WEIGHT = 2'd1,
    RESEND_TARE   = 2'd2
  } resend_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_XON   = 2'd0,
    CFG_XOFF  = 2'd1,
    CFG_FAULT = 2'd2,
    CFG_RETRY = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] xon_code;
    logic [BYTE_W-1:0] xoff_code;
    logic [BYTE_W-1:0] fault_ticks;
    logic [BYTE_W-1:0] retry_ticks;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] second_byte;
    logic              cmd_is_tare;
    logic              run_on;
  } item_t;

  // Control results of one transaction (weight read comes from the store)
  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_data;
    logic              feeder_off;
    logic [1:0]        resend_request;
    logic              running;
    logic              paused;
    logic              comms_fault;
    logic              initialized;
    logic              weight_ready;
    logic [LEN_W-1:0]  weight_len;
  } res_t;

  // Weight store write request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } wr_t;

endpackage

[rtl/slw_in_if.sv]
// ----------------------------------------------------------------------------
// Scale link event channel
// Valid/ready channel carrying one link event per transaction.
// ----------------------------------------------------------------------------
interface slw_in_if;
  import slw_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] data;
  logic [BYTE_W-1:0] second_byte;
  logic              cmd_is_tare;
  logic              run_on;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, func, data, second_byte, cmd_is_tare, run_on,
                  read_index, input ready);
  modport sink   (input valid, func, data, second_byte, cmd_is_tare, run_on,
                  read_index, output ready);
endinterface

[rtl/slw_out_if.sv]
// ----------------------------------------------------------------------------
// Scale link result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface slw_out_if;
  import slw_pkg::*;

  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_data;
  logic              feeder_off;
  logic [1:0]        resend_request;
  logic              running;
  logic              paused;
  logic              comms_fault;
  logic              initialized;
  logic              weight_ready;
  logic [LEN_W-1:0]  weight_len;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, tx_valid, tx_data, feeder_off, resend_request,
                  running, paused, comms_fault, initialized, weight_ready,
                  weight_len, read_data, input ready);
  modport sink   (input valid, tx_valid, tx_data, feeder_off, resend_request,
                  running, paused, comms_fault, initialized, weight_ready,
                  weight_len, read_data, output ready);
endinterface

[rtl/slw_store.sv]
// ----------------------------------------------------------------------------
// Weight byte store
// Register file of received weight bytes, read with write bypass.
// ----------------------------------------------------------------------------
module slw_store (
  input  logic                       clk,
  input  logic                       accept,
  input  slw_pkg::wr_t               wr,
  input  logic [slw_pkg::RIDX_W-1:0] read_index,
  output logic [slw_pkg::BYTE_W-1:0] read_data
);
  import slw_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WEIGHT_DEPTH);

  logic [BYTE_W-1:0] mem [WEIGHT_DEPTH];
  logic [CNT_W-1:0]  ridx_ext;
  logic [IDX_W-1:0]  ridx;

  assign ridx_ext = CNT_W'(read_index);
  assign ridx     = ridx_ext[IDX_W-1:0];

  // Store one byte per write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Register the value after this transaction's write
  always_ff @(posedge clk) begin
    if (accept) begin
      if (ridx_ext >= DEPTH_CNT) begin
        read_data <= '0;
      end else if (wr.en && (wr.addr == ridx)) begin
        read_data <= wr.data;
      end else begin
        read_data <= mem[ridx];
      end
    end
  end

endmodule

[rtl/slw_ctrl.sv]
// ----------------------------------------------------------------------------
// Scale link control
// Watchdog, status flags, receive parser and command transmitter.
// ----------------------------------------------------------------------------
module slw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  slw_pkg::item_t item,
  input  slw_pkg::cfg_t  cfg,
  output slw_pkg::res_t  res,
  output slw_pkg::wr_t   wr
);
  import slw_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WEIGHT_DEPTH);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(CMD_LEN - 1);

  logic [BYTE_W-1:0] watchdog_count, watchdog_count_next, wd_inc;
  logic [CNT_W-1:0]  rx_count, rx_count_next;
  logic [POS_W-1:0]  tx_pos, tx_pos_next;
  logic              tx_pending, tx_pending_next;
  logic              running, running_next;
  logic              paused, paused_next;
  logic              fault, fault_next;
  logic              init, init_next;
  logic              weigh_busy, weigh_busy_next;
  logic              tare_busy, tare_busy_next;
  logic              ready_flag, ready_flag_next;
  logic [LEN_W-1:0]  latched_len, latched_len_next;
  logic [BYTE_W-1:0] tx_store [CMD_LEN];
  logic              load_cmd;

  assign wd_inc = (watchdog_count == WD_MAX) ? watchdog_count : watchdog_count + 8'd1;

  // Decode one event into next state and its result
  always_comb begin
    watchdog_count_next = watchdog_count;
    rx_count_next       = rx_count;
    tx_pos_next         = tx_pos;
    tx_pending_next     = tx_pending;
    running_next        = running;
    paused_next         = paused;
    fault_next          = fault;
    init_next           = init;
    weigh_busy_next     = weigh_busy;
    tare_busy_next      = tare_busy;
    ready_flag_next     = ready_flag;
    latched_len_next    = latched_len;
    load_cmd            = 1'b0;
    wr.en               = 1'b0;
    wr.addr             = rx_count[IDX_W-1:0];
    wr.data             = item.data;
    res.tx_valid        = 1'b0;
    res.tx_data         = '0;
    res.feeder_off      = 1'b0;
    res.resend_request  = RESEND_NONE;

    case (item.func)
      FN_TICK: begin
        if (running) begin
          watchdog_count_next = wd_inc;
          if (wd_inc >= cfg.fault_ticks) begin
            res.feeder_off = 1'b1;
            fault_next     = 1'b1;
            paused_next    = 1'b1;
            running_next   = 1'b0;
          end
        end else if (fault) begin
          watchdog_count_next = wd_inc;
          if (wd_inc >= cfg.retry_ticks) begin
            watchdog_count_next = '0;
            res.resend_request  = tare_busy ? RESEND_TARE : RESEND_WEIGHT;
          end
        end
      end
      FN_RX: begin
        watchdog_count_next = '0;
        if (item.data == cfg.xon_code) begin
          rx_count_next = '0;
        end else if (item.data == cfg.xoff_code) begin
          if (fault) begin
            fault_next   = 1'b0;
            paused_next  = 1'b0;
            running_next = 1'b1;
          end
          if (weigh_busy) begin
            weigh_busy_next  = 1'b0;
            ready_flag_next  = 1'b1;
            latched_len_next = LEN_W'(rx_count);
          end else if (tare_busy) begin
            tare_busy_next = 1'b0;
            init_next      = 1'b1;
          end
        end else if (!tare_busy && (rx_count < DEPTH_CNT)) begin
          wr.en         = accept;
          rx_count_next = rx_count + CNT_W'(1);
        end
      end
      FN_TX_SLOT: begin
        if (tx_pending) begin
          watchdog_count_next = '0;
          res.tx_valid        = 1'b1;
          res.tx_data         = tx_store[tx_pos];
          if (tx_pos == LAST_POS) begin
            tx_pos_next     = '0;
            tx_pending_next = 1'b0;
          end else begin
            tx_pos_next = tx_pos + POS_W'(1);
          end
        end
      end
      FN_START: begin
        load_cmd        = 1'b1;
        tx_pos_next     = '0;
        tx_pending_next = 1'b1;
        if (item.cmd_is_tare) begin
          tare_busy_next = 1'b1;
        end else begin
          weigh_busy_next = 1'b1;
          ready_flag_next = 1'b0;
        end
      end
      FN_RUN: begin
        if (item.run_on) begin
          running_next        = 1'b1;
          paused_next         = 1'b0;
          watchdog_count_next = '0;
        end else begin
          running_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res.running      = running_next;
    res.paused       = paused_next;
    res.comms_fault  = fault_next;
    res.initialized  = init_next;
    res.weight_ready = ready_flag_next;
    res.weight_len   = latched_len_next;
  end

  // Advance control state on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      watchdog_count <= '0;
      rx_count       <= '0;
      tx_pos         <= '0;
      tx_pending     <= 1'b0;
      running        <= 1'b0;
      paused         <= 1'b0;
      fault          <= 1'b0;
      init           <= 1'b0;
      weigh_busy     <= 1'b0;
      tare_busy      <= 1'b0;
      ready_flag     <= 1'b0;
      latched_len    <= '0;
    end else if (accept) begin
      watchdog_count <= watchdog_count_next;
      rx_count       <= rx_count_next;
      tx_pos         <= tx_pos_next;
      tx_pending     <= tx_pending_next;
      running        <= running_next;
      paused         <= paused_next;
      fault          <= fault_next;
      init           <= init_next;
      weigh_busy     <= weigh_busy_next;
      tare_busy      <= tare_busy_next;
      ready_flag     <= ready_flag_next;
      latched_len    <= latched_len_next;
    end
  end

  // Load the command bytes, zero fill past the second
  always_ff @(posedge clk) begin
    if (accept && load_cmd) begin
      for (int i = 0; i < CMD_LEN; i++) begin
        tx_store[i] <= (i == 0) ? item.data : ((i == 1) ? item.second_byte : '0);
      end
    end
  end

`include "scale_link_watchdog_receiver_assert.svh"

  `SLW_ASSERT_SAME(a_feeder_off_faults, res.feeder_off, res.comms_fault && !res.running)
  `SLW_ASSERT_NEXT(a_resend_clears_wd, accept && (res.resend_request != RESEND_NONE), watchdog_count == '0)
  `SLW_ASSERT_SAME(a_idle_tx_pos, !tx_pending, tx_pos == '0)
  `SLW_ASSERT_SAME(a_rx_count_bound, 1'b1, rx_count <= DEPTH_CNT)

endmodule

[rtl/scale_link_watchdog_receiver.sv]
// Latency: a result is valid the cycle after its event is accepted.
// Throughput: one event per cycle while results are taken; the output register frees as it is taken.
// The event decode and the weight store write both complete in the cycle the event is accepted.
// Reset (rst, synchronous): clears flags, counters and the output valid, and
// restores the configuration registers; the byte stores are not cleared.
// ----------------------------------------------------------------------------
// Scale link watchdog receiver
// Top level: configuration registers, control, weight store and result register.
// ----------------------------------------------------------------------------
module scale_link_watchdog_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [slw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slw_pkg::BYTE_W-1:0]    cfg_data,
  slw_in_if.sink                        item,
  slw_out_if.source                     result
);
  import slw_pkg::*;

  cfg_t              cfg;
  item_t             ev;
  res_t              res;
  wr_t               wr;
  logic [BYTE_W-1:0] read_data;
  logic              accept;

  // Take a new transaction whenever the result register is free or draining
  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;

  assign ev.func        = item.func;
  assign ev.data        = item.data;
  assign ev.second_byte = item.second_byte;
  assign ev.cmd_is_tare = item.cmd_is_tare;
  assign ev.run_on      = item.run_on;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.xon_code    <= XON_RST;
      cfg.xoff_code   <= XOFF_RST;
      cfg.fault_ticks <= FAULT_RST;
      cfg.retry_ticks <= RETRY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_XON:   cfg.xon_code    <= cfg_data;
        CFG_XOFF:  cfg.xoff_code   <= cfg_data;
        CFG_FAULT: cfg.fault_ticks <= cfg_data;
        CFG_RETRY: cfg.retry_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  slw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (ev),
    .cfg    (cfg),
    .res    (res),
    .wr     (wr)
  );

  slw_store u_store (
    .clk        (clk),
    .accept     (accept),
    .wr         (wr),
    .read_index (item.read_index),
    .read_data  (read_data)
  );

  // Weight read is registered inside the store
  assign result.read_data = read_data;

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (item.ready) begin
      result.valid <= item.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result.tx_valid       <= res.tx_valid;
      result.tx_data        <= res.tx_data;
      result.feeder_off     <= res.feeder_off;
      result.resend_request <= res.resend_request;
      result.running        <= res.running;
      result.paused         <= res.paused;
      result.comms_fault    <= res.comms_fault;
      result.initialized    <= res.initialized;
      result.weight_ready   <= res.weight_ready;
      result.weight_len     <= res.weight_len;
    end
  end

endmodule
